// ===== hw/rtl/cfa_pkg.sv =====
package cfa_pkg;

  localparam int MaxFrames   = 16384;
  localparam int LaneCnt     = 8;
  localparam int WordCnt     = MaxFrames / LaneCnt;
  localparam int OffW        = $clog2(MaxFrames);
  localparam int WordW       = $clog2(WordCnt);
  localparam int LaneW       = $clog2(LaneCnt);
  localparam int CntW        = 15;
  localparam int FrameW      = 20;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_MARK    = 2'd2;
  localparam logic [1:0] OP_REINIT  = 2'd3;

  localparam logic [1:0] FS_FREE = 2'b00;
  localparam logic [1:0] FS_HEAD = 2'b01;
  localparam logic [1:0] FS_BODY = 2'b11;

  localparam logic [2:0] STS_OK       = 3'd0;
  localparam logic [2:0] STS_SHORT    = 3'd1;
  localparam logic [2:0] STS_NO_RUN   = 3'd2;
  localparam logic [2:0] STS_NOT_HEAD = 3'd3;
  localparam logic [2:0] STS_BAD_ARG  = 3'd4;

  localparam logic [1:0] CFG_BASE  = 2'd0;
  localparam logic [1:0] CFG_POOL  = 2'd1;
  localparam logic [1:0] CFG_MAP   = 2'd2;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [FrameW-1:0] frame_number;
    logic [CntW-1:0]   frame_count;
  } in_t;

  typedef struct packed {
    logic [FrameW-1:0] first_frame;
    logic [2:0]        status;
    logic [CntW-1:0]   free_left;
  } out_t;

endpackage

// ===== hw/rtl/contiguous_frame_allocator.sv =====
// immediate rejects give the registered result in the cycle after the start beat
// allocate: searches the map one 8-frame word at a time for a free run, then marks the run's words
// release and mark: walk the map word by word; reinit: clears all 2048 map words
// one operation at a time; the map is read one 8-frame word per cycle
// reset runs the same map clear with busy high; results cannot be stalled
module contiguous_frame_allocator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  cfa_pkg::in_t               in_data,
  output logic                       out_valid,
  output cfa_pkg::out_t              out_data,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_addr,
  input  logic [cfa_pkg::FrameW-1:0] cfg_wdata
);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CLEAR  = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_MARK   = 3'd3;
  localparam logic [2:0] S_REL    = 3'd4;

  localparam int OffW  = cfa_pkg::OffW;
  localparam int WordW = cfa_pkg::WordW;
  localparam int LaneW = cfa_pkg::LaneW;
  localparam int CntW  = cfa_pkg::CntW;
  localparam int FW    = cfa_pkg::FrameW;
  localparam int LN    = cfa_pkg::LaneCnt;
  localparam int MW    = 2 * LN;

  // frame map: one word holds the 2-bit codes of eight frames
  logic [MW-1:0] map_mem [cfa_pkg::WordCnt];
  logic [MW-1:0] map_q_r;
  logic          map_we;
  logic [WordW-1:0] map_wa;
  logic [MW-1:0] map_wd;

  // config registers (take effect at reinit)
  logic [FW-1:0]   base_cfg_r;
  logic [CntW-1:0] pool_cfg_r;
  logic            map_cfg_r;

  // latched pool and control state
  logic [2:0]       st_r, st_nxt;
  logic [FW-1:0]    act_base_r, act_base_nxt;
  logic [CntW-1:0]  act_size_r, act_size_nxt;
  logic             act_map_r, act_map_nxt;
  logic [CntW-1:0]  free_r, free_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic [OffW-1:0]  off_r, off_nxt;
  logic [WordW-1:0] last_r, last_nxt;
  logic [CntW-1:0]  run_r, run_nxt;
  logic             alloc_r, alloc_nxt;
  logic             first_r, first_nxt;
  logic [WordW-1:0] raddr_r, raddr_nxt;
  logic [WordW-1:0] paddr_r, paddr_nxt;
  logic             pend_r, pend_nxt;
  logic [WordW:0]   clr_r, clr_nxt;
  logic             clr_out_r, clr_out_nxt;
  logic             out_valid_r, out_valid_nxt;
  cfa_pkg::out_t    out_r, out_nxt;

  // pool size clamp for reinit
  logic [CntW-1:0] size_calc;
  always_comb begin
    size_calc = (pool_cfg_r > CntW'(cfa_pkg::MaxFrames)) ? CntW'(cfa_pkg::MaxFrames)
                                                          : pool_cfg_r;
    size_calc = size_calc & ~CntW'(3);
    if (size_calc < CntW'(4)) begin
      size_calc = CntW'(4);
    end
  end

  // range check of the start beat
  logic [FW-1:0]   rel_diff;
  logic            in_pool;
  logic [CntW-1:0] in_off;
  logic [CntW-1:0] room;
  assign rel_diff = in_data.frame_number - act_base_r;
  assign in_pool  = (in_data.frame_number >= act_base_r) &&
                    (rel_diff < FW'(act_size_r));
  assign in_off   = rel_diff[CntW-1:0];
  assign room     = act_size_r - in_off;

  logic [CntW-1:0] size_m1;
  assign size_m1 = act_size_r - CntW'(1);

  always_comb begin
    logic [CntW-1:0] run;
    logic            found;
    logic [CntW-1:0] sidx;
    logic [CntW-1:0] idx;
    logic [CntW-1:0] endx;
    logic [CntW-1:0] last_sum;
    logic [1:0]      cur;
    logic [MW-1:0]   wd;
    logic [3:0]      tally;
    logic            go;
    logic            bad;
    logic            done;
    logic [2:0]      sts;
    logic [FW-1:0]   ff;

    st_nxt        = st_r;
    act_base_nxt  = act_base_r;
    act_size_nxt  = act_size_r;
    act_map_nxt   = act_map_r;
    free_nxt      = free_r;
    cnt_nxt       = cnt_r;
    off_nxt       = off_r;
    last_nxt      = last_r;
    run_nxt       = run_r;
    alloc_nxt     = alloc_r;
    first_nxt     = first_r;
    raddr_nxt     = raddr_r;
    paddr_nxt     = paddr_r;
    pend_nxt      = 1'b0;
    clr_nxt       = clr_r;
    clr_out_nxt   = clr_out_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    map_we        = 1'b0;
    map_wa        = paddr_r;
    map_wd        = map_q_r;
    run           = run_r;
    found         = 1'b0;
    sidx          = '0;
    idx           = '0;
    endx          = CntW'(off_r) + cnt_r;
    last_sum      = '0;
    cur           = '0;
    wd            = map_q_r;
    tally         = '0;
    go            = 1'b1;
    bad           = 1'b0;
    done          = 1'b0;
    sts           = cfa_pkg::STS_OK;
    ff            = '0;

    case (st_r)
      S_IDLE: begin
        if (start) begin
          case (in_data.opcode)
            cfa_pkg::OP_ALLOC: begin
              if (in_data.frame_count == '0) begin
                done = 1'b1;
                sts  = cfa_pkg::STS_BAD_ARG;
              end else if (in_data.frame_count > free_r) begin
                done = 1'b1;
                sts  = cfa_pkg::STS_SHORT;
              end else begin
                st_nxt    = S_SEARCH;
                cnt_nxt   = in_data.frame_count;
                run_nxt   = '0;
                raddr_nxt = '0;
                last_nxt  = size_m1[OffW-1:LaneW];
              end
            end
            cfa_pkg::OP_RELEASE: begin
              if (!in_pool) begin
                done = 1'b1;
                sts  = cfa_pkg::STS_BAD_ARG;
              end else begin
                st_nxt    = S_REL;
                off_nxt   = in_off[OffW-1:0];
                raddr_nxt = in_off[OffW-1:LaneW];
                first_nxt = 1'b1;
                last_nxt  = size_m1[OffW-1:LaneW];
              end
            end
            cfa_pkg::OP_MARK: begin
              if (in_data.frame_count == '0 || !in_pool || in_data.frame_count > room) begin
                done = 1'b1;
                sts  = cfa_pkg::STS_BAD_ARG;
              end else begin
                st_nxt    = S_MARK;
                alloc_nxt = 1'b0;
                off_nxt   = in_off[OffW-1:0];
                cnt_nxt   = in_data.frame_count;
                raddr_nxt = in_off[OffW-1:LaneW];
                last_sum  = in_off + in_data.frame_count - CntW'(1);
                last_nxt  = last_sum[OffW-1:LaneW];
              end
            end
            default: begin
              st_nxt       = S_CLEAR;
              act_size_nxt = size_calc;
              act_base_nxt = base_cfg_r;
              act_map_nxt  = map_cfg_r;
              free_nxt     = map_cfg_r ? size_calc - CntW'(1) : size_calc;
              clr_nxt      = '0;
              clr_out_nxt  = 1'b1;
            end
          endcase
        end
      end

      S_CLEAR: begin
        map_we  = 1'b1;
        map_wa  = clr_r[WordW-1:0];
        map_wd  = '0;
        if (clr_r == '0 && act_map_r) begin
          map_wd[1:0] = cfa_pkg::FS_HEAD;
        end
        clr_nxt = clr_r + 1'b1;
        if (clr_r[WordW-1:0] == {WordW{1'b1}}) begin
          st_nxt = S_IDLE;
          done   = clr_out_r;
        end
      end

      S_SEARCH: begin
        // stream reads, scan returned word for the first long enough run
        pend_nxt  = 1'b1;
        paddr_nxt = raddr_r;
        raddr_nxt = raddr_r + 1'b1;
        if (pend_r) begin
          for (int l = 0; l < LN; l++) begin
            idx = {1'b0, paddr_r, LaneW'(l)};
            cur = map_q_r[2*l +: 2];
            if (!found && idx < act_size_r) begin
              if (cur == cfa_pkg::FS_FREE) begin
                run = run + CntW'(1);
                if (run == cnt_r) begin
                  found = 1'b1;
                  sidx  = idx + CntW'(1) - cnt_r;
                end
              end else begin
                run = '0;
              end
            end
          end
          run_nxt = run;
          if (found) begin
            // restart the read pipe at the run's first word
            st_nxt    = S_MARK;
            pend_nxt  = 1'b0;
            alloc_nxt = 1'b1;
            off_nxt   = sidx[OffW-1:0];
            raddr_nxt = sidx[OffW-1:LaneW];
            last_sum  = sidx + cnt_r - CntW'(1);
            last_nxt  = last_sum[OffW-1:LaneW];
          end else if (paddr_r == last_r) begin
            st_nxt = S_IDLE;
            done   = 1'b1;
            sts    = cfa_pkg::STS_NO_RUN;
          end
        end
      end

      S_MARK: begin
        pend_nxt  = 1'b1;
        paddr_nxt = raddr_r;
        raddr_nxt = raddr_r + 1'b1;
        if (pend_r) begin
          for (int l = 0; l < LN; l++) begin
            idx = {1'b0, paddr_r, LaneW'(l)};
            cur = map_q_r[2*l +: 2];
            if (idx >= CntW'(off_r) && idx < endx) begin
              if (cur == cfa_pkg::FS_FREE) begin
                tally = tally + 4'd1;
              end
              wd[2*l +: 2] = cur | ((idx == CntW'(off_r)) ? cfa_pkg::FS_HEAD
                                                           : cfa_pkg::FS_BODY);
            end
          end
          map_we   = 1'b1;
          map_wd   = wd;
          free_nxt = free_r - CntW'(tally);
          if (paddr_r == last_r) begin
            st_nxt = S_IDLE;
            done   = 1'b1;
            if (alloc_r) begin
              ff = act_base_r + FW'(off_r);
            end
          end
        end
      end

      S_REL: begin
        pend_nxt  = 1'b1;
        paddr_nxt = raddr_r;
        raddr_nxt = raddr_r + 1'b1;
        if (pend_r) begin
          for (int l = 0; l < LN; l++) begin
            idx = {1'b0, paddr_r, LaneW'(l)};
            cur = map_q_r[2*l +: 2];
            if (first_r && LaneW'(l) < off_r[LaneW-1:0]) begin
              // frames before the head stay as they are
            end else if (first_r && LaneW'(l) == off_r[LaneW-1:0]) begin
              if (cur != cfa_pkg::FS_HEAD) begin
                bad = 1'b1;
              end else begin
                wd[2*l +: 2] = cfa_pkg::FS_FREE;
                tally = tally + 4'd1;
              end
            end else if (go && idx < act_size_r && cur == cfa_pkg::FS_BODY) begin
              wd[2*l +: 2] = cfa_pkg::FS_FREE;
              tally = tally + 4'd1;
            end else begin
              go = 1'b0;
            end
          end
          first_nxt = 1'b0;
          if (bad) begin
            st_nxt = S_IDLE;
            done   = 1'b1;
            sts    = cfa_pkg::STS_NOT_HEAD;
          end else begin
            map_we   = 1'b1;
            map_wd   = wd;
            free_nxt = free_r + CntW'(tally);
            if (!go || paddr_r == last_r) begin
              st_nxt = S_IDLE;
              done   = 1'b1;
            end
          end
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase

    if (done) begin
      out_valid_nxt       = 1'b1;
      out_nxt.first_frame = ff;
      out_nxt.status      = sts;
      out_nxt.free_left   = free_nxt;
    end
  end

  // map memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    map_q_r <= map_mem[raddr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_cfg_r  <= '0;
      pool_cfg_r  <= CntW'(cfa_pkg::MaxFrames);
      map_cfg_r   <= 1'b1;
      st_r        <= S_CLEAR;
      act_base_r  <= '0;
      act_size_r  <= CntW'(cfa_pkg::MaxFrames);
      act_map_r   <= 1'b1;
      free_r      <= CntW'(cfa_pkg::MaxFrames - 1);
      clr_r       <= '0;
      clr_out_r   <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          cfa_pkg::CFG_BASE: base_cfg_r <= cfg_wdata;
          cfa_pkg::CFG_POOL: pool_cfg_r <= cfg_wdata[CntW-1:0];
          cfa_pkg::CFG_MAP:  map_cfg_r  <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
      st_r        <= st_nxt;
      act_base_r  <= act_base_nxt;
      act_size_r  <= act_size_nxt;
      act_map_r   <= act_map_nxt;
      free_r      <= free_nxt;
      clr_r       <= clr_nxt;
      clr_out_r   <= clr_out_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // operation payload, no reset needed
  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    off_r   <= off_nxt;
    last_r  <= last_nxt;
    run_r   <= run_nxt;
    alloc_r <= alloc_nxt;
    first_r <= first_nxt;
    raddr_r <= raddr_nxt;
    paddr_r <= paddr_nxt;
    out_r   <= out_nxt;
  end

  assign busy      = (st_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a result beat is only sent on the return to idle
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> st_r == S_IDLE)
    else $error("result beat while sequencer active");

  // free count never exceeds the pool
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= act_size_r)
    else $error("free count above pool size");

  // an accepted beat either starts work or answers right away
  a_start_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid_r))
    else $error("accepted beat dropped");

endmodule

// ===== tb/contiguous_frame_allocator_test.sv =====
`timescale 1ns / 1ps

module contiguous_frame_allocator_test;
  import cfa_pkg::*;

  // frame allocator scoreboard: mirrors the frame map and free count,
  // predicts one result beat per accepted request beat
  class frame_map_scoreboard;
    logic [1:0]        fmap [MaxFrames];
    int unsigned       free_cnt;
    int unsigned       pool_sz;
    logic [FrameW-1:0] pool_base;
    // register copies, latched into the pool only at reinit
    logic [FrameW-1:0] reg_base;
    logic [CntW-1:0]   reg_pool;
    logic              reg_map;
    out_t              expected_q [$];
    int                errors;

    function new();
      reg_base = '0;
      reg_pool = CntW'(MaxFrames);
      reg_map  = 1'b1;
      errors   = 0;
      rebuild_map();
    endfunction

    function void write_reg(logic [1:0] idx, logic [FrameW-1:0] val);
      case (idx)
        CFG_BASE: reg_base = val;
        CFG_POOL: reg_pool = val[CntW-1:0];
        CFG_MAP:  reg_map  = val[0];
        default: ;
      endcase
    endfunction

    function void rebuild_map();
      int unsigned n;
      n = reg_pool;
      if (n > MaxFrames) n = MaxFrames;
      n = n & ~32'd3;
      if (n < 4) n = 4;
      pool_sz   = n;
      pool_base = reg_base;
      foreach (fmap[i]) fmap[i] = FS_FREE;
      free_cnt = n;
      if (reg_map) begin
        fmap[0]  = FS_HEAD;
        free_cnt = n - 1;
      end
    endfunction

    // random head offset inside the pool, or -1 when none
    function int find_head();
      int unsigned s;
      s = $urandom_range(0, pool_sz - 1);
      for (int unsigned k = 0; k < pool_sz; k++)
        if (fmap[(s + k) % pool_sz] == FS_HEAD) return (s + k) % pool_sz;
      return -1;
    endfunction

    function void note_request(in_t b);
      out_t        r;
      int unsigned cnt, fn, off, run, st;
      bit          found;
      r   = '0;
      cnt = b.frame_count;
      fn  = b.frame_number;
      case (b.opcode)
        OP_ALLOC: begin
          if (cnt == 0) r.status = STS_BAD_ARG;
          else if (cnt > free_cnt) r.status = STS_SHORT;
          else begin
            run = 0;
            found = 0;
            for (int unsigned i = 0; i < pool_sz; i++) begin
              if (fmap[i] == FS_FREE) begin
                run++;
                if (run == cnt) begin
                  st = i + 1 - cnt;
                  found = 1;
                  break;
                end
              end else run = 0;
            end
            if (!found) r.status = STS_NO_RUN;
            else begin
              fmap[st] = FS_HEAD;
              for (int unsigned i = st + 1; i < st + cnt; i++) fmap[i] = FS_BODY;
              free_cnt -= cnt;
              r.first_frame = pool_base + FrameW'(st);
            end
          end
        end
        OP_RELEASE: begin
          if (fn < pool_base || fn - pool_base >= pool_sz) r.status = STS_BAD_ARG;
          else begin
            off = fn - pool_base;
            if (fmap[off] != FS_HEAD) r.status = STS_NOT_HEAD;
            else begin
              fmap[off] = FS_FREE;
              free_cnt++;
              for (int unsigned i = off + 1; i < pool_sz && fmap[i] == FS_BODY; i++) begin
                fmap[i] = FS_FREE;
                free_cnt++;
              end
            end
          end
        end
        OP_MARK: begin
          if (cnt == 0 || fn < pool_base || fn - pool_base >= pool_sz ||
              cnt > pool_sz - (fn - pool_base)) r.status = STS_BAD_ARG;
          else begin
            off = fn - pool_base;
            for (int unsigned i = off; i < off + cnt; i++) begin
              if (fmap[i] == FS_FREE) free_cnt--;
              fmap[i] = fmap[i] | ((i == off) ? FS_HEAD : FS_BODY);
            end
          end
        end
        default: rebuild_map();
      endcase
      r.free_left = CntW'(free_cnt);
      expected_q.push_back(r);
    endfunction

    function void check_result(out_t got);
      out_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual %h", $time, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.first_frame !== e.first_frame) begin
        $display("%0t: first_frame expected %h actual %h", $time, e.first_frame,
                 got.first_frame);
        errors++;
      end
      if (got.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
        errors++;
      end
      if (got.free_left !== e.free_left) begin
        $display("%0t: free_left expected %0d actual %0d", $time, e.free_left,
                 got.free_left);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  in_t               in_data;
  logic              out_valid;
  out_t              out_data;
  logic              cfg_we;
  logic [1:0]        cfg_addr;
  logic [FrameW-1:0] cfg_wdata;

  frame_map_scoreboard sb;
  int                  burst_left;

  contiguous_frame_allocator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // results cannot be held off, so every strobe is checked on its edge
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  // drive one request beat; start stays high so a following call chains beats
  task automatic send_request(logic [1:0] op, logic [FrameW-1:0] fn, logic [CntW-1:0] cnt);
    in_t b;
    b.opcode       = op;
    b.frame_number = fn;
    b.frame_count  = cnt;
    start   <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (busy);
    sb.note_request(b);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // block drained: no beat outstanding and the engine not busy
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0 || busy);
  endtask

  // write enable is left high so back-to-back writes chain; the caller drops it
  task automatic write_cfg(logic [1:0] idx, logic [FrameW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // new pool setting, applied through a reinit request
  task automatic set_pool(logic [FrameW-1:0] base, logic [CntW-1:0] frames, logic map_bit);
    wait_drained();
    write_cfg(CFG_BASE, base);
    write_cfg(CFG_POOL, FrameW'(frames));
    write_cfg(CFG_MAP, FrameW'(map_bit));
    cfg_we <= 1'b0;
    send_request(OP_REINIT, FrameW'($urandom), CntW'($urandom));
  endtask

  // one random beat, mostly well-formed allocate/release traffic
  task automatic random_request(int unsigned max_cnt);
    int unsigned sel, cnt;
    int          h;
    logic [FrameW-1:0] fn;
    sel = $urandom_range(0, 99);
    cnt = $urandom_range(1, max_cnt);
    if ($urandom_range(0, 19) == 0) cnt = $urandom_range(0, 32767);
    else if ($urandom_range(0, 29) == 0) cnt = 0;
    fn = sb.pool_base + FrameW'($urandom_range(0, sb.pool_sz - 1));
    if ($urandom_range(0, 14) == 0) fn = FrameW'($urandom);
    if (sel < 48) send_request(OP_ALLOC, fn, CntW'(cnt));
    else if (sel < 83) begin
      h = sb.find_head();
      if (h >= 0 && $urandom_range(0, 4) != 0) fn = sb.pool_base + FrameW'(h);
      send_request(OP_RELEASE, fn, CntW'(cnt));
    end else if (sel < 99) begin
      send_request(OP_MARK, fn, CntW'($urandom_range(0, 3) == 0 ? cnt : cnt % 4 + 1));
    end else send_request(OP_REINIT, fn, CntW'(cnt));
    // sender bursts with random gaps between them
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 7));
    end else burst_left--;
  endtask

  task automatic random_phase(int n, int unsigned max_cnt);
    for (int i = 0; i < n; i++) random_request(max_cnt);
  endtask

  // guard against a hung handshake
  initial begin
    #40_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    sb         = new();
    burst_left = 0;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_addr   = CFG_BASE;
    cfg_wdata  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset pool of 16384 frames, frame 0 holds the map
    send_request(OP_ALLOC, '0, '0);                          // zero count
    send_request(OP_ALLOC, '0, CntW'(MaxFrames));            // shortage
    send_request(OP_ALLOC, '0, CntW'(MaxFrames - 1));        // whole pool
    send_request(OP_RELEASE, 20'd5, '0);                     // body, not a head
    send_request(OP_RELEASE, 20'd1, '0);
    send_request(OP_RELEASE, 20'd16384, '0);                 // past pool end
    send_request(OP_RELEASE, 20'hFFFFF, '0);
    send_request(OP_MARK, 20'd16383, 15'd2);                 // range past the end
    send_request(OP_MARK, 20'd16380, 15'd4);                 // mark to the last frame
    send_request(OP_MARK, 20'd16378, 15'd4);                 // overlapping mark
    send_request(OP_MARK, 20'd10, '0);                       // zero count
    send_request(OP_ALLOC, '0, 15'd16370);                   // run long enough from frame 1
    send_request(OP_RELEASE, 20'd16378, '0);                 // walk to pool end
    send_request(OP_RELEASE, '0, '0);                        // free the map frame
    send_request(OP_ALLOC, '0, 15'd3);
    send_request(OP_MARK, '0, 15'h7FFF);

    // wrap of first_frame past 20 bits, no reserved frame
    set_pool(20'hFFFF8, 15'd64, 1'b0);
    send_request(OP_RELEASE, 20'hFFFF7, '0);                 // below base
    send_request(OP_ALLOC, '0, 15'd20);
    send_request(OP_ALLOC, '0, 15'd44);
    send_request(OP_ALLOC, '0, 15'd1);
    random_phase(200, 10);

    // pool below four frames rounds up to the minimum
    set_pool(20'd1000, 15'd3, 1'b1);
    random_phase(120, 3);
    set_pool(20'h5A5A5, 15'd0, 1'b0);
    random_phase(100, 4);
    set_pool(20'd7, 15'd66, 1'b1);                           // rounds down to 64
    random_phase(260, 12);
    set_pool(20'hA5A5A, 15'd130, 1'b0);
    random_phase(260, 20);
    set_pool(20'd0, 15'h7FFF, 1'b1);                         // clamped to the maximum
    random_phase(30, 4000);
    set_pool(20'd3, 15'd32, 1'b1);
    random_phase(180, 6);

    wait_drained();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
